// ----- rtl/ctb_pkg.sv -----
// Shared types and codes for the countdown timer bank.
// No dependencies; used by ctb_slot_store and countdown_timer_bank_core.
package ctb_pkg;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_ALLOC = 2'd1,
        REQ_FREE  = 2'd2,
        REQ_SET   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_ALLOC = 2'd1,
        ST_RUN   = 2'd2
    } slot_state_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_FREE,
        CMD_SET,
        CMD_ALLOC,
        CMD_TICK
    } cmd_op_t;

    localparam logic EV_ALLOC  = 1'b0;
    localparam logic EV_EXPIRE = 1'b1;

    // One operation on the slot store; the slot index travels beside it
    typedef struct packed {
        cmd_op_t     op;
        logic [3:0]  queue;
        logic [7:0]  payload;
        logic [31:0] timeout;
    } slot_cmd_t;

    // One result item, apart from its last flag
    typedef struct packed {
        logic        event_kind;
        logic [3:0]  timer_slot;
        logic        alloc_ok;
        logic [3:0]  queue_out;
        logic [7:0]  data_out;
        logic [31:0] tick_now;
    } result_t;

endpackage

// ----- rtl/ctb_slot_store.sv -----
// Per-slot timer storage: state, remaining count, queue id and payload byte,
// plus the one shared decrement-and-compare unit. Depends on ctb_pkg.
module ctb_slot_store #(
    parameter int SLOTS = 16,
    parameter int IDX_W = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctb_pkg::slot_cmd_t     cmd,
    input  logic [IDX_W-1:0]       idx,
    output ctb_pkg::slot_state_t   rd_status,
    output logic [3:0]             rd_queue,
    output logic [7:0]             rd_payload,
    output logic                   expire
);
    import ctb_pkg::*;

    slot_state_t status_reg  [SLOTS];
    logic [31:0] remain_reg  [SLOTS];
    logic [3:0]  queue_reg   [SLOTS];
    logic [7:0]  payload_reg [SLOTS];

    logic [31:0] remain_next;
    logic        remain_zero;
    logic        running;
    logic [31:0] load_value;

    assign rd_status  = status_reg[idx];
    assign rd_queue   = queue_reg[idx];
    assign rd_payload = payload_reg[idx];

    // Shared unit: one decrement and zero compare for the addressed slot
    assign running     = (rd_status == ST_RUN);
    assign remain_next = remain_reg[idx] - 32'd1;
    assign remain_zero = (remain_next == 32'd0);
    assign expire      = running && remain_zero;

    // Treat a zero timeout as one tick
    assign load_value = (cmd.timeout == 32'd0) ? 32'd1 : cmd.timeout;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                status_reg[i] <= ST_FREE;
            end
        end
        else
        begin
            unique case (cmd.op)
                CMD_FREE:  status_reg[idx] <= ST_FREE;
                CMD_SET:   status_reg[idx] <= ST_RUN;
                CMD_ALLOC: status_reg[idx] <= ST_ALLOC;
                CMD_TICK:
                begin
                    if (expire)
                    begin
                        status_reg[idx] <= ST_ALLOC;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_SET)
        begin
            queue_reg[idx]   <= cmd.queue;
            payload_reg[idx] <= cmd.payload;
            remain_reg[idx]  <= load_value;
        end
        else if (cmd.op == CMD_TICK && running)
        begin
            remain_reg[idx] <= remain_next;
        end
    end

endmodule

// ----- rtl/countdown_timer_bank_core.sv -----
// Countdown timer bank top level: request sequencer and result registers.
// Depends on ctb_pkg and ctb_slot_store.
//
// Usage: requests enter on the in_* channel (req_type, timer_index,
// dest_queue, payload, timeout); results leave on the out_* channel. A
// transfer happens on a rising edge with valid high and stall low.
// Free and set write the slot in the accepting cycle, and the next request
// can follow immediately. They produce no result. Tick and allocate walk the
// slots one per cycle (a tick only while not held) through a single shared
// decrement/compare unit with in_stall high: a tick scans min(NUM_TIMERS,16)
// slots, an allocate stops at the first free one, and a flush state hands
// off the final result. An allocate gives one result; a tick gives one per
// expiring timer, with last set on the final one, and none without expiry.
// An expiry result waits in a pending register until the next one is found
// or the scan ends, which is how last is known. If the receiver stalls while
// a pending result needs to move, the scan holds on its slot and resumes
// when the output register frees, so stalls add cycles 1:1. The final
// result sits in the output register, so the next request is taken while
// it still waits to be taken.
// Reset: all timers free and the tick count zero; no clearing pass.
module countdown_timer_bank_core #(
    parameter int NUM_TIMERS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [3:0]  timer_index,
    input  logic [3:0]  dest_queue,
    input  logic [7:0]  payload,
    input  logic [31:0] timeout,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        event_kind,
    output logic [3:0]  timer_slot,
    output logic        alloc_ok,
    output logic [3:0]  queue_out,
    output logic [7:0]  data_out,
    output logic [31:0] tick_now,
    output logic        last
);
    import ctb_pkg::*;

    // Only sixteen slots are addressable through the 4-bit index fields
    localparam int SLOTS = (NUM_TIMERS < 16) ? NUM_TIMERS : 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } state_t;

    state_t           state_reg;
    req_t             req_reg;
    logic [IDX_W-1:0] scan_idx_reg;
    logic [31:0]      tick_total_reg;
    result_t          pend_reg;
    logic             pend_valid_reg;
    result_t          out_reg;
    logic             out_last_reg;
    logic             out_valid_reg;

    logic             accept_in;
    logic             in_range;
    logic             out_free;
    logic             scan_go;
    logic             out_load;
    req_t             req_in;
    slot_cmd_t        cmd;
    logic [IDX_W-1:0] store_idx;
    slot_state_t      rd_status;
    logic [3:0]       rd_queue;
    logic [7:0]       rd_payload;
    logic             expire;

    assign req_in    = req_t'(req_type);
    assign in_stall  = (state_reg != S_IDLE);
    assign accept_in = in_valid && !in_stall;
    assign in_range  = ({1'b0, timer_index} < 5'(SLOTS));
    assign out_free  = !out_valid_reg || !out_stall;

    // Hold the tick scan while a pending result cannot move on
    assign scan_go = !(pend_valid_reg && !out_free);

    // Load the output register from the pending one: a newer expiry pushes
    // the older one out, and the flush hands off the final result
    assign out_load = (state_reg == S_SCAN && req_reg == REQ_TICK && scan_go
                       && expire && pend_valid_reg)
                   || (state_reg == S_FLUSH && pend_valid_reg && out_free);

    always_comb
    begin
        cmd.op      = CMD_NONE;
        cmd.queue   = dest_queue;
        cmd.payload = payload;
        cmd.timeout = timeout;
        store_idx   = scan_idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                store_idx = timer_index[IDX_W-1:0];
                if (accept_in && in_range)
                begin
                    if (req_in == REQ_FREE)
                    begin
                        cmd.op = CMD_FREE;
                    end
                    else if (req_in == REQ_SET)
                    begin
                        cmd.op = CMD_SET;
                    end
                end
            end
            S_SCAN:
            begin
                if (req_reg == REQ_ALLOC)
                begin
                    if (rd_status == ST_FREE)
                    begin
                        cmd.op = CMD_ALLOC;
                    end
                end
                else if (scan_go)
                begin
                    cmd.op = CMD_TICK;
                end
            end
            S_FLUSH: ;
            default: ;
        endcase
    end

    ctb_slot_store #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .idx        (store_idx),
        .rd_status  (rd_status),
        .rd_queue   (rd_queue),
        .rd_payload (rd_payload),
        .expire     (expire)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            req_reg        <= REQ_TICK;
            scan_idx_reg   <= '0;
            tick_total_reg <= 32'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // Raise valid on a load; drop it once the receiver takes it
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept_in && (req_in == REQ_TICK || req_in == REQ_ALLOC))
                    begin
                        req_reg      <= req_in;
                        scan_idx_reg <= '0;
                        state_reg    <= S_SCAN;
                        if (req_in == REQ_TICK)
                        begin
                            tick_total_reg <= tick_total_reg + 32'd1;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (req_reg == REQ_ALLOC)
                    begin
                        // Lowest free slot wins; a full scan with none fails
                        if (rd_status == ST_FREE || scan_idx_reg == LAST_IDX)
                        begin
                            pend_reg.event_kind <= EV_ALLOC;
                            pend_reg.timer_slot <= (rd_status == ST_FREE)
                                                   ? 4'(scan_idx_reg) : 4'd0;
                            pend_reg.alloc_ok   <= (rd_status == ST_FREE);
                            pend_reg.queue_out  <= 4'd0;
                            pend_reg.data_out   <= 8'd0;
                            pend_reg.tick_now   <= 32'd0;
                            pend_valid_reg      <= 1'b1;
                            state_reg           <= S_FLUSH;
                        end
                        else
                        begin
                            scan_idx_reg <= scan_idx_reg + 1'b1;
                        end
                    end
                    else if (scan_go)
                    begin
                        if (expire)
                        begin
                            // Advance the previous expiry; it is not the final one
                            if (pend_valid_reg)
                            begin
                                out_reg       <= pend_reg;
                                out_last_reg  <= 1'b0;
                            end
                            pend_reg.event_kind <= EV_EXPIRE;
                            pend_reg.timer_slot <= 4'(scan_idx_reg);
                            pend_reg.alloc_ok   <= 1'b0;
                            pend_reg.queue_out  <= rd_queue;
                            pend_reg.data_out   <= rd_payload;
                            pend_reg.tick_now   <= tick_total_reg;
                            pend_valid_reg      <= 1'b1;
                        end
                        if (scan_idx_reg == LAST_IDX)
                        begin
                            state_reg <= S_FLUSH;
                        end
                        else
                        begin
                            scan_idx_reg <= scan_idx_reg + 1'b1;
                        end
                    end
                end
                S_FLUSH:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_reg        <= pend_reg;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = out_reg.event_kind;
    assign timer_slot = out_reg.timer_slot;
    assign alloc_ok   = out_reg.alloc_ok;
    assign queue_out  = out_reg.queue_out;
    assign data_out   = out_reg.data_out;
    assign tick_now   = out_reg.tick_now;
    assign last       = out_last_reg;

`ifndef NO_ASSERTIONS
    // A new request never arrives while a result of the previous one is pending
    a_no_pend_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |-> !pend_valid_reg)
        else $error("request accepted with a pending result");

    // A successful allocation names an existing slot
    a_alloc_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.event_kind == EV_ALLOC && out_reg.alloc_ok)
        |-> ({1'b0, out_reg.timer_slot} < 5'(SLOTS)))
        else $error("allocation reply names a missing slot");

    // Each accepted tick advances the tick count by exactly one
    a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_in && req_in == REQ_TICK)
        |=> (tick_total_reg == $past(tick_total_reg) + 32'd1))
        else $error("tick count did not advance by one");

    // A stalled pending result freezes the tick scan
    a_scan_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && req_reg == REQ_TICK && !scan_go)
        |=> $stable(scan_idx_reg))
        else $error("tick scan advanced while blocked");
`endif

endmodule
